### rtl/ptt_pkg.sv
// Package with the command, table and state codes of the periodic task timer bank.
package ptt_pkg;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_RUN        = 3'd1,
    CMD_CREATE     = 3'd2,
    CMD_SET_STATE  = 3'd3,
    CMD_SET_TICK   = 3'd4,
    CMD_SET_PERIOD = 3'd5,
    CMD_SET_DELAY  = 3'd6,
    CMD_GET_TICK   = 3'd7
  } cmd_e;

  localparam logic [1:0] KIND_DELAYED = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_TIMER   = 2'd2;

  localparam int unsigned MaxResults = 16;
  localparam logic [15:0] TickStepReset = 16'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_EV,
    ST_TICK_DL,
    ST_TICK_TM,
    ST_RUN_DL,
    ST_RUN_EV,
    ST_REPLY
  } state_e;

endpackage

### rtl/periodic_task_timer_bank.sv
// Top level of the periodic task timer bank with its slot tables and sequencer.
// A tick walks every created slot one per cycle through a shared adder, first the events,
// then the delayed tasks, then the timers, and then replies. A run walks the created
// delayed tasks and then the events likewise, stops early after 16 reports, waits while
// the output is stalled, and ends with a word that has last set. Other commands go
// straight to the reply. The input stalls while a command is in progress; tick_step
// may be written only while the block is idle.
module periodic_task_timer_bank #(
  parameter int unsigned DELAYED_SLOTS = 8,
  parameter int unsigned EVENT_SLOTS   = 8,
  parameter int unsigned TIMER_SLOTS   = 8,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  slot_i,
  input  logic [31:0] value_i,
  input  logic        enable_i,
  input  logic        has_handler_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [1:0]  out_kind_o,
  output logic [2:0]  out_slot_o,
  output logic [31:0] out_value_o,
  output logic        fired_o,
  output logic        last_o
);
  import ptt_pkg::*;

  localparam int unsigned DW = (DELAYED_SLOTS > 1) ? $clog2(DELAYED_SLOTS) : 1;
  localparam int unsigned EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned TW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned IW = 6;
  localparam int unsigned CW = 6;
  localparam int unsigned SW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [15:0] step_q;
  logic [IW-1:0] dl_used_q, ev_used_q, tm_used_q;
  logic [DELAYED_SLOTS-1:0] dl_en_q, dl_h_q;
  logic [TIME_BITS-1:0] dl_left_q [DELAYED_SLOTS];
  logic [EVENT_SLOTS-1:0] ev_en_q, ev_h_q, ev_pend_q;
  logic [TIME_BITS-1:0] ev_per_q [EVENT_SLOTS];
  logic [TIME_BITS-1:0] ev_cnt_q [EVENT_SLOTS];
  logic [TIMER_SLOTS-1:0] tm_en_q;
  logic [TIME_BITS-1:0] tm_cnt_q [TIMER_SLOTS];

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] nrep_q, nrep_d;

  logic ov_q;
  logic o_status_q, o_fired_q, o_last_q;
  logic [1:0] o_kind_q;
  logic [2:0] o_slot_q;
  logic [31:0] o_value_q;

  logic [2:0] cmd_q;
  logic [1:0] kind_q;
  logic [2:0] slot_q;
  logic [TIME_BITS-1:0] value_q;
  logic en_q, h_q;

  logic out_free, accept;
  assign out_free = ~ov_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = ov_q;
  assign status_o = o_status_q;
  assign out_kind_o = o_kind_q;
  assign out_slot_o = o_slot_q;
  assign out_value_o = o_value_q;
  assign fired_o = o_fired_q;
  assign last_o = o_last_q;

  // Shared adder operand selection.
  logic [TIME_BITS-1:0] alu_a, alu_res;
  logic alu_sub;
  logic [DW-1:0] di;
  logic [EW-1:0] ei;
  logic [TW-1:0] ti;
  assign di = idx_q[DW-1:0];
  assign ei = idx_q[EW-1:0];
  assign ti = idx_q[TW-1:0];

  always_comb begin
    alu_a = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_TICK_EV: alu_a = ev_cnt_q[ei];
      ST_TICK_DL: begin
        alu_a = dl_left_q[di];
        alu_sub = 1'b1;
      end
      ST_TICK_TM: alu_a = tm_cnt_q[ti];
      default: alu_a = '0;
    endcase
  end

  ptt_alu #(.TimeBits(TIME_BITS)) u_alu (
    .a_i(alu_a), .step_i(step_q), .sub_i(alu_sub), .res_o(alu_res)
  );

  // Walk control signals.
  logic ev_in, dl_in, tm_in;
  assign ev_in = (idx_q < ev_used_q);
  assign dl_in = (idx_q < dl_used_q);
  assign tm_in = (idx_q < tm_used_q);
  logic dl_rep, ev_vis, ev_rep, full;
  assign full = (nrep_q >= CW'(MaxResults));
  assign dl_rep = dl_in & dl_en_q[di] & (dl_left_q[di] == '0) & dl_h_q[di];
  assign ev_vis = ev_in & ev_en_q[ei] & ev_pend_q[ei];
  assign ev_rep = ev_vis & ev_h_q[ei];

  // Single command decode.
  logic slot_ok, err;
  logic [IW-1:0] slot_ext;
  assign slot_ext = IW'(slot_q);
  always_comb begin
    slot_ok = 1'b0;
    case (kind_q)
      KIND_DELAYED: slot_ok = slot_ext < dl_used_q;
      KIND_EVENT:   slot_ok = slot_ext < ev_used_q;
      KIND_TIMER:   slot_ok = slot_ext < tm_used_q;
      default:      slot_ok = 1'b0;
    endcase
    err = 1'b0;
    case (cmd_e'(cmd_q))
      CMD_CREATE: begin
        case (kind_q)
          KIND_DELAYED: err = dl_used_q >= IW'(DELAYED_SLOTS);
          KIND_EVENT:   err = (SW'(value_q) < SW'(step_q)) || (ev_used_q >= IW'(EVENT_SLOTS));
          KIND_TIMER:   err = tm_used_q >= IW'(TIMER_SLOTS);
          default:      err = 1'b1;
        endcase
      end
      CMD_SET_STATE:  err = ~slot_ok;
      CMD_SET_TICK:   err = ~slot_ok | (kind_q == KIND_DELAYED);
      CMD_SET_PERIOD: err = ~slot_ok | (kind_q != KIND_EVENT);
      CMD_SET_DELAY:  err = ~slot_ok | (kind_q != KIND_DELAYED);
      CMD_GET_TICK:   err = ~slot_ok | (kind_q != KIND_TIMER);
      default:        err = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    nrep_d = nrep_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        nrep_d = '0;
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_TICK: state_d = ST_TICK_EV;
            CMD_RUN:  state_d = ST_RUN_DL;
            default:  state_d = ST_REPLY;
          endcase
        end
      end
      ST_TICK_EV: begin
        if (ev_in) idx_d = idx_q + 1'b1;
        else begin
          idx_d = '0;
          state_d = ST_TICK_DL;
        end
      end
      ST_TICK_DL: begin
        if (dl_in) idx_d = idx_q + 1'b1;
        else begin
          idx_d = '0;
          state_d = ST_TICK_TM;
        end
      end
      ST_TICK_TM: begin
        if (tm_in) idx_d = idx_q + 1'b1;
        else state_d = ST_REPLY;
      end
      ST_RUN_DL: begin
        if (!dl_in || full) begin
          idx_d = '0;
          state_d = ST_RUN_EV;
        end else if (!dl_rep || out_free) begin
          idx_d = idx_q + 1'b1;
          if (dl_rep) nrep_d = nrep_q + 1'b1;
        end
      end
      ST_RUN_EV: begin
        if (!ev_in || full) begin
          state_d = ST_REPLY;
        end else if (!ev_rep || out_free) begin
          idx_d = idx_q + 1'b1;
          if (ev_rep) nrep_d = nrep_q + 1'b1;
        end
      end
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Pending result word of the run and reply states, read by the output block below.
  logic         lw_valid;
  logic         lw_status, lw_fired, lw_last;
  logic [1:0]   lw_kind;
  logic [2:0]   lw_slot;
  logic [31:0]  lw_value;
  // A run stages each found report in the held word, since the final word has to carry last;
  // a report is held back there until the next one is known.
  logic hold_q;

  always_comb begin
    lw_valid = 1'b0;
    lw_status = 1'b0;
    lw_fired = 1'b0;
    lw_last = 1'b0;
    lw_kind = '0;
    lw_slot = '0;
    lw_value = '0;
    case (state_q)
      ST_RUN_DL: begin
        if (dl_in && !full && dl_rep) begin
          lw_valid = 1'b1;
          lw_fired = 1'b1;
          lw_kind = KIND_DELAYED;
          lw_slot = 3'(idx_q);
        end
      end
      ST_RUN_EV: begin
        if (ev_in && !full && ev_rep) begin
          lw_valid = 1'b1;
          lw_fired = 1'b1;
          lw_kind = KIND_EVENT;
          lw_slot = 3'(idx_q);
        end
      end
      ST_REPLY: begin
        if (cmd_e'(cmd_q) == CMD_RUN) begin
          lw_valid = (nrep_q == '0);
          lw_last = 1'b1;
        end else begin
          lw_valid = 1'b1;
          lw_last = 1'b1;
          if (err) lw_status = 1'b1;
          else if (cmd_e'(cmd_q) == CMD_TICK) lw_kind = '0;
          else begin
            lw_kind = kind_q;
            lw_slot = slot_q;
            if (cmd_e'(cmd_q) == CMD_CREATE) begin
              case (kind_q)
                KIND_DELAYED: lw_slot = 3'(dl_used_q);
                KIND_EVENT:   lw_slot = 3'(ev_used_q);
                default:      lw_slot = 3'(tm_used_q);
              endcase
            end
            if (cmd_e'(cmd_q) == CMD_GET_TICK) lw_value = 32'(tm_cnt_q[slot_ext[TW-1:0]]);
          end
        end
      end
      default: lw_valid = 1'b0;
    endcase
  end

  // Output register. During a run, reports are staged in the held word; the held word
  // goes out when the next report appears, or with last set when the walk ends.
  logic         hw_fired_q;
  logic [1:0]   hw_kind_q;
  logic [2:0]   hw_slot_q;
  logic run_end;
  assign run_end = (state_q == ST_REPLY) && (cmd_e'(cmd_q) == CMD_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      hold_q <= 1'b0;
    end else if (out_free) begin
      if (hold_q && (lw_valid && lw_fired || run_end)) begin
        ov_q <= 1'b1;
        hold_q <= lw_valid && lw_fired;
      end else if (lw_valid && lw_fired) begin
        ov_q <= 1'b0;
        hold_q <= 1'b1;
      end else begin
        ov_q <= lw_valid && state_q == ST_REPLY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (hold_q && (lw_valid && lw_fired || run_end)) begin
        o_status_q <= 1'b0;
        o_fired_q <= hw_fired_q;
        o_kind_q <= hw_kind_q;
        o_slot_q <= hw_slot_q;
        o_value_q <= '0;
        o_last_q <= run_end;
      end else begin
        o_status_q <= lw_status;
        o_fired_q <= lw_fired;
        o_kind_q <= lw_kind;
        o_slot_q <= lw_slot;
        o_value_q <= lw_value;
        o_last_q <= lw_last;
      end
      if (lw_valid && lw_fired) begin
        hw_fired_q <= 1'b1;
        hw_kind_q <= lw_kind;
        hw_slot_q <= lw_slot;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      nrep_q <= '0;
      step_q <= TickStepReset;
      dl_used_q <= '0;
      ev_used_q <= '0;
      tm_used_q <= '0;
      ev_pend_q <= '0;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        ev_per_q[i] <= '0;
        ev_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      nrep_q <= nrep_d;
      if (cfg_valid_i) step_q <= cfg_data_i;
      case (state_q)
        ST_TICK_EV: begin
          if (ev_in) begin
            if (ev_en_q[ei]) begin
              if (ev_cnt_q[ei] >= ev_per_q[ei]) begin
                ev_pend_q[ei] <= 1'b1;
                ev_cnt_q[ei] <= '0;
              end else ev_cnt_q[ei] <= alu_res;
            end else ev_pend_q[ei] <= 1'b0;
          end
        end
        ST_RUN_EV: begin
          if (ev_in && !full && ev_vis && (!ev_rep || out_free)) ev_pend_q[ei] <= 1'b0;
        end
        ST_REPLY: begin
          if (out_free && !err) begin
            case (cmd_e'(cmd_q))
              CMD_CREATE: begin
                case (kind_q)
                  KIND_DELAYED: dl_used_q <= dl_used_q + 1'b1;
                  KIND_EVENT: begin
                    ev_used_q <= ev_used_q + 1'b1;
                    ev_per_q[ev_used_q[EW-1:0]] <= value_q;
                    ev_cnt_q[ev_used_q[EW-1:0]] <= '0;
                  end
                  default: tm_used_q <= tm_used_q + 1'b1;
                endcase
              end
              CMD_SET_STATE: begin
                if (kind_q == KIND_EVENT) ev_cnt_q[slot_ext[EW-1:0]] <= '0;
              end
              CMD_SET_TICK: begin
                if (kind_q == KIND_EVENT) begin
                  ev_cnt_q[slot_ext[EW-1:0]] <= value_q;
                  ev_pend_q[slot_ext[EW-1:0]] <= 1'b0;
                end
              end
              CMD_SET_PERIOD: begin
                ev_cnt_q[slot_ext[EW-1:0]] <= '0;
                ev_pend_q[slot_ext[EW-1:0]] <= 1'b0;
                ev_per_q[slot_ext[EW-1:0]] <= value_q;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Payload tables without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      kind_q <= kind_i;
      slot_q <= slot_i;
      value_q <= TIME_BITS'(value_i);
      en_q <= enable_i;
      h_q <= has_handler_i;
    end
    case (state_q)
      ST_TICK_DL: if (dl_in) dl_left_q[di] <= alu_res;
      ST_TICK_TM: if (tm_in && tm_en_q[ti]) tm_cnt_q[ti] <= alu_res;
      ST_REPLY: begin
        if (out_free && !err) begin
          case (cmd_e'(cmd_q))
            CMD_CREATE: begin
              case (kind_q)
                KIND_DELAYED: begin
                  dl_en_q[dl_used_q[DW-1:0]] <= en_q;
                  dl_h_q[dl_used_q[DW-1:0]] <= h_q;
                  dl_left_q[dl_used_q[DW-1:0]] <= '0;
                end
                KIND_EVENT: begin
                  ev_en_q[ev_used_q[EW-1:0]] <= en_q;
                  ev_h_q[ev_used_q[EW-1:0]] <= h_q;
                end
                default: begin
                  tm_en_q[tm_used_q[TW-1:0]] <= en_q;
                  tm_cnt_q[tm_used_q[TW-1:0]] <= '0;
                end
              endcase
            end
            CMD_SET_STATE: begin
              case (kind_q)
                KIND_DELAYED: begin
                  dl_en_q[slot_ext[DW-1:0]] <= en_q;
                  dl_left_q[slot_ext[DW-1:0]] <= '0;
                end
                KIND_EVENT: ev_en_q[slot_ext[EW-1:0]] <= en_q;
                default: begin
                  tm_en_q[slot_ext[TW-1:0]] <= en_q;
                  tm_cnt_q[slot_ext[TW-1:0]] <= '0;
                end
              endcase
            end
            CMD_SET_TICK: if (kind_q == KIND_TIMER) tm_cnt_q[slot_ext[TW-1:0]] <= value_q;
            CMD_SET_DELAY: dl_left_q[slot_ext[DW-1:0]] <= value_q;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end
endmodule

### rtl/ptt_alu.sv
// Shared time arithmetic unit: one add or subtract with compare per cycle.
module ptt_alu #(
  parameter int unsigned TimeBits = 32
) (
  input  logic [TimeBits-1:0] a_i,
  input  logic [15:0]         step_i,
  input  logic                sub_i,
  output logic [TimeBits-1:0] res_o
);
  localparam int unsigned SumBits = ((TimeBits > 16) ? TimeBits : 16) + 1;

  logic [SumBits-1:0] a_ext;
  logic [SumBits-1:0] step_ext;
  logic [SumBits-1:0] sum;
  logic               ge;

  assign a_ext = SumBits'(a_i);
  assign step_ext = SumBits'(step_i);
  assign sum = sub_i ? (a_ext - step_ext) : (a_ext + step_ext);
  assign ge = ~sum[SumBits-1];
  assign res_o = sub_i ? (ge ? sum[TimeBits-1:0] : '0) : sum[TimeBits-1:0];
endmodule

### sim/periodic_task_timer_bank_checker.sv
// Checker that predicts and compares every result word of the periodic task timer bank.
`timescale 1ns / 100ps
module periodic_task_timer_bank_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  cmd_i,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  slot_i,
  input  logic [31:0] value_i,
  input  logic        enable_i,
  input  logic        has_handler_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic [1:0]  out_kind_i,
  input  logic [2:0]  out_slot_i,
  input  logic [31:0] out_value_i,
  input  logic        fired_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          reports_o
);
  import ptt_pkg::*;

  typedef struct packed {
    logic        status;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] value;
    logic        fired;
    logic        last;
  } reply_t;

  reply_t      replies_q[$];
  logic [15:0] step;
  int unsigned dl_used, ev_used, tm_used;
  logic        dl_en[8], dl_hd[8], ev_en[8], ev_hd[8], ev_pend[8], tm_en[8];
  logic [31:0] dl_left[8], ev_period[8], ev_count[8], tm_count[8];

  function automatic reply_t make_reply(logic st, logic [1:0] k, logic [2:0] s,
                                        logic [31:0] v, logic f, logic l);
    reply_t r;
    r.status = st; r.kind = k; r.slot = s; r.value = v; r.fired = f; r.last = l;
    return r;
  endfunction

  task automatic push_error();
    replies_q.push_back(make_reply(1'b1, 2'd0, 3'd0, 32'd0, 1'b0, 1'b1));
  endtask

  task automatic push_ok(logic [1:0] k, logic [2:0] s, logic [31:0] v);
    replies_q.push_back(make_reply(1'b0, k, s, v, 1'b0, 1'b1));
  endtask

  task automatic advance_tables();
    for (int i = 0; i < ev_used; i++) begin
      if (ev_en[i]) begin
        if (ev_count[i] >= ev_period[i]) begin
          ev_pend[i] = 1'b1;
          ev_count[i] = '0;
        end else begin
          ev_count[i] = ev_count[i] + step;
        end
      end else begin
        ev_pend[i] = 1'b0;
      end
    end
    for (int i = 0; i < dl_used; i++) begin
      dl_left[i] = (dl_left[i] >= step) ? dl_left[i] - step : '0;
    end
    for (int i = 0; i < tm_used; i++) begin
      if (tm_en[i]) begin
        tm_count[i] = tm_count[i] + step;
      end
    end
  endtask

  task automatic collect_run();
    int n;
    n = 0;
    for (int i = 0; i < dl_used && n < MaxResults; i++) begin
      if (dl_en[i] && dl_left[i] == 0 && dl_hd[i]) begin
        replies_q.push_back(make_reply(1'b0, KIND_DELAYED, 3'(i), 32'd0, 1'b1, 1'b0));
        n++;
      end
    end
    for (int i = 0; i < ev_used && n < MaxResults; i++) begin
      if (ev_en[i] && ev_pend[i]) begin
        ev_pend[i] = 1'b0;
        if (ev_hd[i]) begin
          replies_q.push_back(make_reply(1'b0, KIND_EVENT, 3'(i), 32'd0, 1'b1, 1'b0));
          n++;
        end
      end
    end
    if (n == 0) begin
      push_ok(2'd0, 3'd0, 32'd0);
    end else begin
      replies_q[$].last = 1'b1;
    end
  endtask

  task automatic predict_command(cmd_e c, logic [1:0] k, logic [2:0] s, logic [31:0] v,
                                 logic en, logic hd);
    case (c)
      CMD_TICK: begin
        advance_tables();
        push_ok(2'd0, 3'd0, 32'd0);
      end
      CMD_RUN: collect_run();
      CMD_CREATE: begin
        if (k == KIND_DELAYED && dl_used < 8) begin
          dl_en[dl_used] = en; dl_hd[dl_used] = hd; dl_left[dl_used] = '0;
          push_ok(k, 3'(dl_used), 32'd0);
          dl_used++;
        end else if (k == KIND_EVENT && v >= step && ev_used < 8) begin
          ev_en[ev_used] = en; ev_hd[ev_used] = hd;
          ev_period[ev_used] = v; ev_count[ev_used] = '0;
          push_ok(k, 3'(ev_used), 32'd0);
          ev_used++;
        end else if (k == KIND_TIMER && tm_used < 8) begin
          tm_en[tm_used] = en; tm_count[tm_used] = '0;
          push_ok(k, 3'(tm_used), 32'd0);
          tm_used++;
        end else begin
          push_error();
        end
      end
      default: begin
        if (!((k == KIND_DELAYED && s < dl_used) || (k == KIND_EVENT && s < ev_used)
              || (k == KIND_TIMER && s < tm_used))) begin
          push_error();
        end else begin
          case (c)
            CMD_SET_STATE: begin
              if (k == KIND_DELAYED) begin
                dl_en[s] = en; dl_left[s] = '0;
              end else if (k == KIND_EVENT) begin
                ev_en[s] = en; ev_count[s] = '0;
              end else begin
                tm_en[s] = en; tm_count[s] = '0;
              end
              push_ok(k, s, 32'd0);
            end
            CMD_SET_TICK: begin
              if (k == KIND_EVENT) begin
                ev_count[s] = v; ev_pend[s] = 1'b0; push_ok(k, s, 32'd0);
              end else if (k == KIND_TIMER) begin
                tm_count[s] = v; push_ok(k, s, 32'd0);
              end else begin
                push_error();
              end
            end
            CMD_SET_PERIOD: begin
              if (k == KIND_EVENT) begin
                ev_count[s] = '0; ev_pend[s] = 1'b0; ev_period[s] = v;
                push_ok(k, s, 32'd0);
              end else begin
                push_error();
              end
            end
            CMD_SET_DELAY: begin
              if (k == KIND_DELAYED) begin
                dl_left[s] = v; push_ok(k, s, 32'd0);
              end else begin
                push_error();
              end
            end
            default: begin
              if (k == KIND_TIMER) push_ok(k, s, tm_count[s]);
              else push_error();
            end
          endcase
        end
      end
    endcase
  endtask

  assign pending_o = replies_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      step <= TickStepReset;
      dl_used <= 0; ev_used <= 0; tm_used <= 0;
      for (int i = 0; i < 8; i++) begin
        ev_period[i] <= '0; ev_count[i] <= '0; ev_pend[i] <= 1'b0;
      end
      replies_q.delete();
      mismatches_o <= 0;
      reports_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        step = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_command(cmd_e'(cmd_i), kind_i, slot_i, value_i, enable_i, has_handler_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got = make_reply(status_i, out_kind_i, out_slot_i, out_value_i, fired_i, last_i);
        if (got.fired) reports_o <= reports_o + 1;
        if (replies_q.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected result word %p", got);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = replies_q.pop_front();
          if (want != got) begin
            if (mismatches_o < 10) $display("mismatch: expected %p, got %p", want, got);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

endmodule

### sim/periodic_task_timer_bank_test.sv
// Testbench top that drives commands and tick_step writes into the periodic task timer bank.
`timescale 1ns / 100ps
module periodic_task_timer_bank_test;
  import ptt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [1:0]  kind_i = '0;
  logic [2:0]  slot_i = '0;
  logic [31:0] value_i = '0;
  logic        enable_i = 1'b0;
  logic        has_handler_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        status_o;
  logic [1:0]  out_kind_o;
  logic [2:0]  out_slot_o;
  logic [31:0] out_value_o;
  logic        fired_o;
  logic        last_o;
  int          mismatches, pending, reports;
  bit          hold_long = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  periodic_task_timer_bank dut (.*);

  periodic_task_timer_bank_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .kind_i, .slot_i, .value_i,
    .enable_i, .has_handler_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .out_kind_i(out_kind_o), .out_slot_i(out_slot_o), .out_value_i(out_value_o),
    .fired_i(fired_o), .last_i(last_o), .mismatches_o(mismatches), .pending_o(pending),
    .reports_o(reports)
  );

  // The receiver stalls at random before each word, or for a long stretch on request.
  initial begin
    int gap;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_long = 1'b0;
      end
      gap = $urandom_range(3);
      if ($urandom_range(7) == 0) gap = 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(cmd_e c, logic [1:0] k, logic [2:0] s, logic [31:0] v,
                           logic en, logic hd);
    int gap;
    gap = $urandom_range(3);
    repeat (gap) @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= c; kind_i <= k; slot_i <= s; value_i <= v;
    enable_i <= en; has_handler_i <= hd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_step(logic [15:0] d);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_word();
    int pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(1000));
    if (pick < 30) send_word(CMD_TICK, 2'($urandom), 3'($urandom), $urandom(), 1'($urandom),
                             1'($urandom));
    else if (pick < 45) send_word(CMD_RUN, 2'($urandom), 3'($urandom), v, 1'($urandom),
                                  1'($urandom));
    else if (pick < 52) send_word(CMD_CREATE, 2'($urandom_range(3)), 3'($urandom), v,
                                  ($urandom_range(3) != 0), 1'($urandom));
    else send_word(cmd_e'($urandom_range(3, 7)), ($urandom_range(9) == 0) ? 2'd3 :
                   2'($urandom_range(2)), 3'($urandom), v, ($urandom_range(3) != 0),
                   1'($urandom));
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // An empty run and errors on empty tables, then fill the tables past their capacity.
    send_word(CMD_RUN, 2'd0, 3'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_GET_TICK, KIND_TIMER, 3'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_CREATE, KIND_EVENT, 3'd0, 32'd99, 1'b1, 1'b1);
    send_word(CMD_CREATE, 2'd3, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) begin
      send_word(CMD_CREATE, KIND_DELAYED, 3'd0, 32'd0, 1'b1, 1'b1);
      send_word(CMD_CREATE, KIND_EVENT, 3'd0, (i == 0) ? 32'd100 : 32'd300, 1'b1, 1'b1);
      send_word(CMD_CREATE, KIND_TIMER, 3'd0, 32'd0, 1'b1, 1'b0);
    end
    send_word(CMD_SET_TICK, KIND_TIMER, 3'd1, 32'hFFFF_FFF0, 1'b0, 1'b0);
    send_word(CMD_SET_TICK, KIND_DELAYED, 3'd1, 32'd5, 1'b0, 1'b0);
    send_word(CMD_SET_PERIOD, KIND_TIMER, 3'd1, 32'd5, 1'b0, 1'b0);
    send_word(CMD_SET_DELAY, KIND_EVENT, 3'd1, 32'd5, 1'b0, 1'b0);
    send_word(CMD_SET_DELAY, KIND_DELAYED, 3'd2, 32'd150, 1'b0, 1'b0);
    send_word(CMD_SET_STATE, KIND_EVENT, 3'd3, 32'd0, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) send_word(CMD_TICK, 2'd0, 3'd0, 32'd0, 1'b0, 1'b0);
    // A run with many reports; the receiver holds off so the block backs up.
    hold_long = 1'b1;
    send_word(CMD_RUN, 2'd0, 3'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_RUN, 2'd0, 3'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_GET_TICK, KIND_TIMER, 3'd1, 32'd0, 1'b0, 1'b0);
    send_word(CMD_GET_TICK, KIND_EVENT, 3'd1, 32'd0, 1'b0, 1'b0);

    write_step(16'hFFFF);
    for (int i = 0; i < 70; i++) random_word();
    write_step(16'd1);
    for (int i = 0; i < 70; i++) random_word();
    write_step(16'($urandom_range(1, 65535)));
    for (int i = 0; i < 66; i++) random_word();

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
